### src/ctlz_pkg.sv
// ----------------------------------------------------------------------------
// ctlz_pkg: shared types and codes for the case table LZ decoder
// Operation codes, sequencer states, the memory request bundle and the
// lookup result bundle passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
package ctlz_pkg;

  // Operation codes carried on the operation port
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Width of a table word and of a table index on the ports
  localparam int unsigned WORD_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_LOOK
  } ctlz_state_t;

  // One write port and one read port of the table memory
  typedef struct packed {
    logic              we;
    logic [WORD_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [WORD_W-1:0] raddr;
  } ctlz_mem_t;

  // Lookup result handed to the output register
  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] value;
    logic              written;
    logic              err;
  } ctlz_res_t;

endpackage

### src/ctlz_ram.sv
// ----------------------------------------------------------------------------
// ctlz_ram: generic single write, single read memory
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
module ctlz_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register read data only when asked so it holds otherwise
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/ctlz_seq.sv
// ----------------------------------------------------------------------------
// ctlz_seq: load and lookup sequencer
// Walks literal, copy and lookup operations one table word at a time,
// keeping the fill position and the sticky error flag.
// ----------------------------------------------------------------------------
module ctlz_seq #(
  parameter int unsigned TABLE_ENTRIES = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [15:0]                 run_length,
  input  logic [15:0]                 source_position,
  input  logic [15:0]                 code_unit,
  output ctlz_pkg::ctlz_mem_t         mem,
  input  logic [15:0]                 rdata,
  input  logic                        out_free,
  output ctlz_pkg::ctlz_res_t         res
);
  import ctlz_pkg::*;

  localparam int unsigned FW = $clog2(TABLE_ENTRIES) + 1;
  localparam logic [FW-1:0] FILL_MAX = FW'(TABLE_ENTRIES);

  ctlz_state_t       state, state_next;
  logic [15:0]       cnt, cnt_next;
  logic [15:0]       src, src_next;
  logic              hit, hit_next;
  logic [FW-1:0]     fill, fill_next;
  logic              err, err_next;
  logic              full;
  logic              src_ok;

  // Compares against the fill position; full is shared by literals and copies
  assign full   = (fill >= FILL_MAX);
  assign src_ok = ({1'b0, src} < 17'(fill));

  // Hold state, counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      err   <= err_next;
    end
    cnt <= cnt_next;
    src <= src_next;
    hit <= hit_next;
  end

  // Next state, memory requests and result
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    src_next   = src;
    hit_next   = hit;
    fill_next  = fill;
    err_next   = err;
    mem        = '0;
    res        = '0;
    in_ready   = (state == ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op == OP_LOOKUP) begin
            mem.re     = 1'b1;
            mem.raddr  = code_unit;
            src_next   = code_unit;
            hit_next   = ({1'b0, code_unit} < 17'(fill));
            state_next = ST_LOOK;
          end else if (run_length == '0) begin
            // Literal: store the value or flag an overflow
            if (full) begin
              err_next = 1'b1;
            end else begin
              mem.we    = 1'b1;
              mem.waddr = 16'(fill);
              mem.wdata = source_position;
              fill_next = fill + 1'b1;
            end
          end else begin
            cnt_next   = run_length;
            src_next   = source_position;
            state_next = ST_COPY_RD;
          end
        end
      end

      ST_COPY_RD: begin
        if (full) begin
          // Drop the rest of the copy
          err_next   = 1'b1;
          state_next = ST_IDLE;
        end else if (src_ok) begin
          mem.re     = 1'b1;
          mem.raddr  = src;
          state_next = ST_COPY_WR;
        end else begin
          // Unwritten source: store zero and flag it
          mem.we     = 1'b1;
          mem.waddr  = 16'(fill);
          mem.wdata  = '0;
          err_next   = 1'b1;
          fill_next  = fill + 1'b1;
          src_next   = src + 1'b1;
          cnt_next   = cnt - 1'b1;
          state_next = (cnt == 16'd1) ? ST_IDLE : ST_COPY_RD;
        end
      end

      ST_COPY_WR: begin
        mem.we     = 1'b1;
        mem.waddr  = 16'(fill);
        mem.wdata  = rdata;
        fill_next  = fill + 1'b1;
        src_next   = src + 1'b1;
        cnt_next   = cnt - 1'b1;
        state_next = (cnt == 16'd1) ? ST_IDLE : ST_COPY_RD;
      end

      ST_LOOK: begin
        // Wait for the output register, then apply the delta on read
        if (out_free) begin
          res.load    = 1'b1;
          res.value   = hit ? (rdata + src) : '0;
          res.written = hit;
          res.err     = err;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/case_table_lz_decoder_core.sv
// ----------------------------------------------------------------------------
// case_table_lz_decoder_core: LZ table builder with delta-filtered lookups
// Builds a 16-bit upper-case table from literal and copy pairs and answers
// lookups with the stored word plus the index, or zero if not yet written.
// ----------------------------------------------------------------------------
// A literal pair is written to the table straight from the idle state.
// A copy reads each word from the single-read-port table memory and then
// writes it; a copy cut short by a full table ends early. A lookup reads
// the table and, after the registered memory read, waits until the output
// register is free to take its result. The block takes one item at a time;
// a waiting lookup result does not stop later loads. No clearing pass: the
// fill position alone decides which entries count as written.
module case_table_lz_decoder_core #(
  parameter int unsigned TABLE_ENTRIES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [15:0] run_length,
  input  logic [15:0] source_position,
  input  logic [15:0] code_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] upper_value,
  output logic        entry_written,
  output logic        load_error
);
  import ctlz_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  ctlz_mem_t   mem;
  ctlz_res_t   res;
  logic [15:0] rdata;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  ctlz_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (operation),
    .run_length      (run_length),
    .source_position (source_position),
    .code_unit       (code_unit),
    .mem             (mem),
    .rdata           (rdata),
    .out_free        (out_free),
    .res             (res)
  );

  ctlz_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr[AW-1:0]),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr[AW-1:0]),
    .rdata (rdata)
  );

  // Hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res.load) begin
      upper_value   <= res.value;
      entry_written <= res.written;
      load_error    <= res.err;
    end
  end

endmodule
